[rtl/lsbse_pkg.sv]
// Shared types and codes for the LSB steganography stream extractor.
`timescale 1ns / 1ps

package lsbse_pkg;

  localparam int HdrW = 10;
  localparam int MagW = 8;
  localparam int CfgW = 10;
  localparam int CfgIdxW = 2;

  // parser phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_MAGIC  = 3'd1;
  localparam logic [2:0] PH_EXTLEN = 3'd2;
  localparam logic [2:0] PH_EXT    = 3'd3;
  localparam logic [2:0] PH_PAYLEN = 3'd4;
  localparam logic [2:0] PH_PAY    = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;
  localparam logic [2:0] PH_HALT   = 3'd7;

  // result kinds
  localparam logic [1:0] KIND_EXT   = 2'd0;
  localparam logic [1:0] KIND_PAY   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_HEADER_BYTES = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAGIC_FIRST  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAGIC_SECOND = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } result_t;

endpackage

[rtl/lsb_stego_stream_extractor.sv]
// Top level: LSB steganography stream extractor with output and skid registers.
`timescale 1ns / 1ps

// Each result is registered in out_r, or in the skid register while out_r is held.
// Throughput: one image byte per cycle unless stalled; the parser updates on acceptance.
// A skid register holds a second result, so in_stall rises only when both are full.
// Reset (synchronous, rst_n low): parser to header skip, counters cleared, registers to
// 54 / '#' / '*', output and skid registers emptied.
module lsb_stego_stream_extractor
  import lsbse_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_image_byte,
  input  logic                in_start_of_file,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_out_byte,
  output logic [1:0]          out_kind,
  output logic                out_last_of_section
);

  logic [HdrW-1:0] header_bytes_r;
  logic [MagW-1:0] magic_first_r;
  logic [MagW-1:0] magic_second_r;

  logic [2:0]      phase_r, phase_nxt;
  logic [HdrW-1:0] header_count_r, header_count_nxt;
  logic [4:0]      bit_count_r, bit_count_nxt;
  logic [31:0]     bit_shift_r, bit_shift_nxt;
  logic            magic_index_r, magic_index_nxt;
  logic            magic_bad_r, magic_bad_nxt;
  logic [31:0]     remaining_r, remaining_nxt;

  logic    res_valid;
  result_t res;

  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;

  logic in_acc, out_acc;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_acc   = out_valid_r && !out_stall;

  assign out_out_byte        = out_r.data;
  assign out_kind            = out_r.kind;
  assign out_last_of_section = out_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_bytes_r <= HdrW'(54);
      magic_first_r  <= MagW'(35);
      magic_second_r <= MagW'(42);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER_BYTES: header_bytes_r <= cfg_data;
        REG_MAGIC_FIRST:  magic_first_r  <= cfg_data[MagW-1:0];
        REG_MAGIC_SECOND: magic_second_r <= cfg_data[MagW-1:0];
        default: ;
      endcase
    end
  end

  // parser: one byte per accepted item
  always_comb begin
    logic [2:0]  ph;
    logic        byte_done;
    logic        len_done;
    logic        bad;
    logic [31:0] shifted;
    logic [31:0] rem_dec;

    phase_nxt        = phase_r;
    header_count_nxt = header_count_r;
    bit_count_nxt    = bit_count_r;
    bit_shift_nxt    = bit_shift_r;
    magic_index_nxt  = magic_index_r;
    magic_bad_nxt    = magic_bad_r;
    remaining_nxt    = remaining_r;
    res_valid        = 1'b0;
    res              = '0;

    if (in_start_of_file) begin
      phase_nxt        = PH_HEADER;
      header_count_nxt = '0;
      bit_count_nxt    = '0;
      bit_shift_nxt    = '0;
      magic_index_nxt  = 1'b0;
      magic_bad_nxt    = 1'b0;
      remaining_nxt    = '0;
    end

    ph = phase_nxt;
    if (ph == PH_HEADER) begin
      if (header_count_nxt < header_bytes_r) begin
        header_count_nxt = header_count_nxt + HdrW'(1);
      end else begin
        ph = PH_MAGIC;
        phase_nxt = PH_MAGIC;
      end
    end

    shifted   = {bit_shift_nxt[30:0], in_image_byte[0]};
    byte_done = (bit_count_nxt >= 5'd7);
    len_done  = (bit_count_nxt >= 5'd31);
    rem_dec   = remaining_nxt - 32'd1;
    bad       = magic_bad_nxt | (shifted[7:0] !=
                (magic_index_nxt ? magic_second_r : magic_first_r));

    unique case (ph)
      PH_MAGIC, PH_EXT, PH_PAY: begin
        bit_shift_nxt = shifted;
        bit_count_nxt = byte_done ? 5'd0 : bit_count_nxt + 5'd1;
      end
      PH_EXTLEN, PH_PAYLEN: begin
        bit_shift_nxt = shifted;
        bit_count_nxt = len_done ? 5'd0 : bit_count_nxt + 5'd1;
      end
      default: ;
    endcase

    unique case (ph)
      PH_MAGIC: begin
        if (byte_done) begin
          magic_bad_nxt = bad;
          if (!magic_index_nxt) begin
            magic_index_nxt = 1'b1;
          end else if (bad) begin
            phase_nxt = PH_HALT;
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
          end else begin
            phase_nxt = PH_EXTLEN;
          end
        end
      end
      PH_EXTLEN: begin
        if (len_done) begin
          remaining_nxt = shifted;
          phase_nxt     = (shifted != '0) ? PH_EXT : PH_PAYLEN;
        end
      end
      PH_PAYLEN: begin
        if (len_done) begin
          remaining_nxt = shifted;
          phase_nxt     = (shifted != '0) ? PH_PAY : PH_DONE;
        end
      end
      PH_EXT, PH_PAY: begin
        if (byte_done) begin
          remaining_nxt = rem_dec;
          res_valid     = 1'b1;
          res.data      = shifted[7:0];
          res.kind      = (ph == PH_EXT) ? KIND_EXT : KIND_PAY;
          res.last      = (rem_dec == '0);
          if (rem_dec == '0) begin
            phase_nxt = (ph == PH_EXT) ? PH_PAYLEN : PH_DONE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      header_count_r <= '0;
      bit_count_r    <= '0;
      bit_shift_r    <= '0;
      magic_index_r  <= 1'b0;
      magic_bad_r    <= 1'b0;
      remaining_r    <= '0;
    end else if (in_acc) begin
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      bit_count_r    <= bit_count_nxt;
      bit_shift_r    <= bit_shift_nxt;
      magic_index_r  <= magic_index_nxt;
      magic_bad_r    <= magic_bad_nxt;
      remaining_r    <= remaining_nxt;
    end
  end

  // output register with skid behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_acc) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_acc && res_valid;
        end
      end else if (in_acc && res_valid) begin
        if (out_valid_r) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc && skid_valid_r) begin
      out_r <= skid_r;
    end else if (in_acc && res_valid && (out_acc || !out_valid_r)) begin
      out_r <= res;
    end
    if (in_acc && res_valid && out_valid_r && !out_acc) begin
      skid_r <= res;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_valid && res.kind == KIND_ERROR) |=> phase_r == PH_HALT)
    else $error("magic error result without halt");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_start_of_file && (phase_r == PH_DONE || phase_r == PH_HALT))
    |-> !res_valid)
    else $error("result produced after payload or halt");

  a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_MAGIC || phase_r == PH_EXT || phase_r == PH_PAY)
    |-> bit_count_r < 5'd8)
    else $error("bit count overran a byte field");

endmodule

[tb/sv/lsbse_extract_check.sv]
// Channel monitor for the LSB stego extractor: predicts hidden bytes and compares results.
`timescale 1ns / 1ps

module lsbse_extract_check
  import lsbse_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_image_byte,
  input  logic               in_start_of_file,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         out_out_byte,
  input  logic [1:0]         out_kind,
  input  logic               out_last_of_section,
  output int                 mismatches,
  output int                 awaited
);

  localparam logic [HdrW-1:0] HDR_RESET          = 10'd54;
  localparam logic [MagW-1:0] MAGIC_FIRST_RESET  = 8'd35;
  localparam logic [MagW-1:0] MAGIC_SECOND_RESET = 8'd42;

  logic [HdrW-1:0] hdr_len;
  logic [MagW-1:0] magic_a;
  logic [MagW-1:0] magic_b;

  logic [2:0]      phase;
  logic [HdrW-1:0] hdr_cnt;
  logic [4:0]      bit_cnt;
  logic [31:0]     shreg;
  logic            magic_idx;
  logic            magic_err;
  logic [31:0]     left_cnt;

  result_t hidden_q[$];

  initial begin
    mismatches = 0;
    awaited    = 0;
  end

  task automatic report(input string what, input logic [7:0] want_v, input logic [7:0] got_v);
    $display("%0t: bad result, %s expected %0d got %0d", $time, what, want_v, got_v);
    mismatches++;
  endtask

  function automatic void clear_parser();
    phase     = PH_HEADER;
    hdr_cnt   = '0;
    bit_cnt   = '0;
    shreg     = '0;
    magic_idx = 1'b0;
    magic_err = 1'b0;
    left_cnt  = '0;
  endfunction

  // true once a field of 'need' bits has been gathered
  function automatic bit shift_in(input logic b, input int unsigned need);
    shreg = {shreg[30:0], b};
    if (32'(bit_cnt) >= need - 1) begin
      bit_cnt = '0;
      return 1'b1;
    end
    bit_cnt = bit_cnt + 5'd1;
    return 1'b0;
  endfunction

  task automatic predict_hidden(input logic [7:0] b, input logic sof);
    result_t r;
    bit      got;
    got = 1'b0;
    r   = '0;
    if (sof) clear_parser();
    if (phase == PH_HEADER) begin
      if (hdr_cnt < hdr_len) begin
        hdr_cnt = hdr_cnt + HdrW'(1);
        return;
      end
      phase = PH_MAGIC;
    end
    case (phase)
      PH_MAGIC: begin
        if (shift_in(b[0], 8)) begin
          if (shreg[7:0] != (magic_idx ? magic_b : magic_a)) magic_err = 1'b1;
          if (!magic_idx) begin
            magic_idx = 1'b1;
          end else if (magic_err) begin
            phase  = PH_HALT;
            r.data = 8'h00;
            r.kind = KIND_ERROR;
            r.last = 1'b0;
            got    = 1'b1;
          end else begin
            phase = PH_EXTLEN;
          end
        end
      end
      PH_EXTLEN, PH_PAYLEN: begin
        if (shift_in(b[0], 32)) begin
          left_cnt = shreg;
          if (phase == PH_EXTLEN) phase = (shreg != 0) ? PH_EXT : PH_PAYLEN;
          else phase = (shreg != 0) ? PH_PAY : PH_DONE;
        end
      end
      PH_EXT, PH_PAY: begin
        if (shift_in(b[0], 8)) begin
          left_cnt = left_cnt - 1;
          r.data   = shreg[7:0];
          r.kind   = (phase == PH_EXT) ? KIND_EXT : KIND_PAY;
          r.last   = (left_cnt == 0);
          got      = 1'b1;
          if (left_cnt == 0) phase = (phase == PH_EXT) ? PH_PAYLEN : PH_DONE;
        end
      end
      default: ;
    endcase
    if (got) hidden_q.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (!rst_n) begin
      hdr_len = HDR_RESET;
      magic_a = MAGIC_FIRST_RESET;
      magic_b = MAGIC_SECOND_RESET;
      clear_parser();
      hidden_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen.data = out_out_byte;
        seen.kind = out_kind;
        seen.last = out_last_of_section;
        if (hidden_q.size() == 0) begin
          report("unrequested item, out_byte", 8'h00, seen.data);
        end else begin
          want = hidden_q.pop_front();
          if (seen.data != want.data) report("out_byte", want.data, seen.data);
          if (seen.kind != want.kind) report("kind", 8'(want.kind), 8'(seen.kind));
          if (seen.last != want.last) report("last_of_section", 8'(want.last), 8'(seen.last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_HEADER_BYTES: hdr_len = cfg_data[HdrW-1:0];
          REG_MAGIC_FIRST:  magic_a = cfg_data[MagW-1:0];
          REG_MAGIC_SECOND: magic_b = cfg_data[MagW-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_hidden(in_image_byte, in_start_of_file);
    end
    awaited <= hidden_q.size();
  end

endmodule

[tb/sv/tb_lsb_stego_stream_extractor.sv]
// Testbench top: stimulus, receiver stalls and verdict for the LSB stego extractor.
`timescale 1ns / 1ps

module tb_lsb_stego_stream_extractor;
  import lsbse_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int MIN_ITEMS   = 600;

  typedef enum int {FILE_GOOD, FILE_BAD_MAGIC, FILE_CUT, FILE_NOISE} file_shape_t;

  logic               clk                 = 1'b0;
  logic               rst_n               = 1'b0;
  logic               cfg_we              = 1'b0;
  logic [CfgIdxW-1:0] cfg_index           = '0;
  logic [CfgW-1:0]    cfg_data            = '0;
  logic               in_valid            = 1'b0;
  logic               in_stall;
  logic [7:0]         in_image_byte       = 8'h00;
  logic               in_start_of_file    = 1'b0;
  logic               out_valid;
  logic               out_stall           = 1'b0;
  logic [7:0]         out_out_byte;
  logic [1:0]         out_kind;
  logic               out_last_of_section;

  int mismatches;
  int awaited;

  int  cycle_count = 0;
  int  items_sent  = 0;
  int  burst_left  = 0;
  int  file_budget = 0;
  bit  sof_next    = 1'b0;
  bit  hold_req    = 1'b0;

  logic [HdrW-1:0] cur_hdr = 10'd54;
  logic [7:0]      cur_m1  = 8'd35;
  logic [7:0]      cur_m2  = 8'd42;

  always #5 clk = ~clk;

  lsb_stego_stream_extractor dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_image_byte       (in_image_byte),
    .in_start_of_file    (in_start_of_file),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_out_byte        (out_out_byte),
    .out_kind            (out_kind),
    .out_last_of_section (out_last_of_section)
  );

  lsbse_extract_check u_extract_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_image_byte       (in_image_byte),
    .in_start_of_file    (in_start_of_file),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_out_byte        (out_out_byte),
    .out_kind            (out_kind),
    .out_last_of_section (out_last_of_section),
    .mismatches          (mismatches),
    .awaited             (awaited)
  );

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= LIMIT);
    $display("lsb_stego_stream_extractor: mismatch");
    $finish;
  end

  // receiver: random stall density in spans, plus one long hold on request
  initial begin : receiver
    int span;
    int pct;
    span = 0;
    pct  = 0;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (span == 0) begin
          span = $urandom_range(10, 80);
          case ($urandom_range(0, 3))
            0:       pct = 0;
            1:       pct = 25;
            2:       pct = 60;
            default: pct = 90;
          endcase
        end
        span--;
        out_stall <= ($urandom_range(0, 99) < pct);
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic sof);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
    end
    in_valid         <= 1'b1;
    in_image_byte    <= b;
    in_start_of_file <= sof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic configure(input logic [HdrW-1:0] hdr, input logic [7:0] m1, input logic [7:0] m2);
    write_reg(REG_HEADER_BYTES, CfgW'(hdr));
    write_reg(REG_MAGIC_FIRST, {2'($urandom), m1});
    write_reg(REG_MAGIC_SECOND, {2'($urandom), m2});
    cfg_we  <= 1'b0;
    cur_hdr = hdr;
    cur_m1  = m1;
    cur_m2  = m2;
  endtask

  // sender idles until every hidden byte is back, then a short settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic file_item(input logic [7:0] b);
    if (file_budget > 0) begin
      send_item(b, sof_next);
      sof_next = 1'b0;
      file_budget--;
    end
  endtask

  task automatic file_bits(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) file_item({7'($urandom), v[i]});
  endtask

  task automatic send_file(input file_shape_t shape, input bit long_pay);
    logic [31:0] ext_len;
    logic [31:0] pay_len;
    logic [7:0]  m1;
    logic [7:0]  m2;
    int          n;
    sof_next    = 1'b1;
    file_budget = 1 << 30;
    if (shape == FILE_NOISE) begin
      n = $urandom_range(1, 30);
      repeat (n) begin
        file_item(8'($urandom));
        sof_next = ($urandom_range(0, 9) == 0);
      end
      return;
    end
    m1 = cur_m1;
    m2 = cur_m2;
    if (shape == FILE_BAD_MAGIC) begin
      case ($urandom_range(0, 2))
        0: m1 = m1 ^ 8'($urandom_range(1, 255));
        1: m2 = m2 ^ 8'($urandom_range(1, 255));
        default: begin
          m1 = ~m1;
          m2 = m2 ^ 8'h80;
        end
      endcase
    end
    ext_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
    if (long_pay) pay_len = $urandom_range(18, 24);
    else pay_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (shape == FILE_CUT) begin
      if ($urandom_range(0, 1)) ext_len = $urandom;
      else pay_len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
      file_budget = cur_hdr + 48 + $urandom_range(0, 100);
    end
    repeat (cur_hdr) file_item(8'($urandom));
    file_bits(m1, 8);
    file_bits(m2, 8);
    if (shape == FILE_BAD_MAGIC) begin
      repeat ($urandom_range(0, 12)) file_item(8'($urandom));
      return;
    end
    file_bits(ext_len, 32);
    for (longint i = 0; i < ext_len && file_budget > 0; i++) file_bits($urandom, 8);
    file_bits(pay_len, 32);
    if (long_pay) hold_req = 1'b1;
    for (longint i = 0; i < pay_len && file_budget > 0; i++) file_bits($urandom, 8);
    repeat ($urandom_range(0, 4)) file_item(8'($urandom));
  endtask

  initial begin : stimulus
    logic [HdrW-1:0] hdr;
    logic [7:0]      m1;
    logic [7:0]      m2;
    int              phase_no;
    int              n_files;
    file_shape_t     shape;
    bit              long_pay;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: magic mismatch on the second byte, halted input, restarts
    configure(10'd0, 8'hFF, 8'h00);
    for (int i = 0; i < 8; i++) send_item((i % 2) ? 8'hFF : 8'h01, i == 0);
    for (int i = 0; i < 7; i++) send_item((i % 2) ? 8'h00 : 8'hFE, 1'b0);
    send_item(8'h81, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h7F, 1'b0);
    drain_results();

    phase_no = 0;
    while (items_sent < MIN_ITEMS) begin
      case (phase_no)
        0:       hdr = 10'd0;
        1:       hdr = 10'd150;
        default: begin
          case ($urandom_range(0, 3))
            0:       hdr = 10'd0;
            1:       hdr = HdrW'($urandom_range(1, 12));
            2:       hdr = 10'd54;
            default: hdr = HdrW'($urandom_range(13, 90));
          endcase
        end
      endcase
      case ($urandom_range(0, 3))
        0: begin
          m1 = 8'd35;
          m2 = 8'd42;
        end
        1: begin
          m1 = 8'($urandom);
          m2 = 8'($urandom);
        end
        2: begin
          m1 = 8'h00;
          m2 = 8'hFF;
        end
        default: begin
          m1 = 8'hFF;
          m2 = 8'h00;
        end
      endcase
      configure(hdr, m1, m2);
      n_files = (hdr > 100) ? 1 : $urandom_range(2, 4);
      for (int f = 0; f < n_files; f++) begin
        long_pay = (phase_no == 0 && f == 0);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: shape = FILE_GOOD;
          6:                shape = FILE_BAD_MAGIC;
          7, 8:             shape = FILE_CUT;
          default:          shape = FILE_NOISE;
        endcase
        if (long_pay || hdr > 100) shape = FILE_GOOD;
        send_file(shape, long_pay);
      end
      drain_results();
      phase_no++;
    end

    if (mismatches == 0) begin
      $display("lsb_stego_stream_extractor: match");
    end else begin
      $display("lsb_stego_stream_extractor: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/lsbse_pkg.sv
rtl/lsb_stego_stream_extractor.sv
tb/sv/lsbse_extract_check.sv
tb/sv/tb_lsb_stego_stream_extractor.sv
